>>> design/pstat_pkg.sv
// Shared types, codes and widths of the primitive statistics counter.
// No dependencies; every other design file imports this package.
package pstat_pkg;

    localparam int CNT_W      = 32;   // vertex and primitive count width
    localparam int CTR_W      = 48;   // statistics counter width
    localparam int FRAMES_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int Q_DEPTH    = 4;    // command queue between front and back
    localparam int OUT_DEPTH  = 2;    // result queue
    localparam int NUM_SLOTS  = 4;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COUNTING_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART_IDX = 2'd2;

    // counter slots
    localparam logic [1:0] SLOT_POINTS = 2'd0;
    localparam logic [1:0] SLOT_LINES  = 2'd1;
    localparam logic [1:0] SLOT_TRIS   = 2'd2;
    localparam logic [1:0] SLOT_VERTS  = 2'd3;

    // primitive modes
    localparam logic [3:0] MODE_VERTICES   = 4'd0;
    localparam logic [3:0] MODE_POINTS     = 4'd1;
    localparam logic [3:0] MODE_LINES      = 4'd2;
    localparam logic [3:0] MODE_LINE_LOOP  = 4'd3;
    localparam logic [3:0] MODE_LINE_STRIP = 4'd4;
    localparam logic [3:0] MODE_TRIS       = 4'd5;
    localparam logic [3:0] MODE_TRI_STRIP  = 4'd6;
    localparam logic [3:0] MODE_FAN        = 4'd7;
    localparam logic [3:0] MODE_QUADS      = 4'd8;
    localparam logic [3:0] MODE_QUAD_STRIP = 4'd9;
    localparam logic [3:0] MODE_POLYGON    = 4'd10;
    localparam logic [3:0] MODE_LINES_ADJ  = 4'd11;
    localparam logic [3:0] MODE_STRIP_ADJ  = 4'd12;
    localparam logic [3:0] MODE_TRIS_ADJ   = 4'd13;
    localparam logic [3:0] MODE_TSTRIP_ADJ = 4'd14;

    typedef enum logic [2:0] {
        CMD_DRAW        = 3'd0,
        CMD_DRAW_ARRAYS = 3'd1,
        CMD_BEGIN       = 3'd2,
        CMD_END         = 3'd3,
        CMD_ARRAY_ELEM  = 3'd4,
        CMD_FRAME_END   = 3'd5,
        CMD_CLEAR       = 3'd6
    } cmd_t;

    // what the back end does with a queued word
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_COUNT = 2'd1,
        OP_FRAME = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    // classified command: up to two batches in one mode
    typedef struct packed {
        op_t              op;
        logic             drawn;
        logic [3:0]       mode;
        logic [CNT_W-1:0] n1;
        logic [CNT_W-1:0] n2;
    } cmd_entry_t;

    typedef struct packed {
        logic [CTR_W-1:0]    points;
        logic [CTR_W-1:0]    lines;
        logic [CTR_W-1:0]    tris;
        logic [CTR_W-1:0]    verts;
        logic [FRAMES_W-1:0] frames;
        logic [CNT_W-1:0]    added;
    } result_t;

endpackage

>>> design/pstat_front.sv
// Front end: configuration registers, begin/end block tracking and restart
// splitting; turns each accepted command into a queue word. Uses pstat_pkg.
module pstat_front
    import pstat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  accept,
    input  logic [2:0]            cmd,
    input  logic [3:0]            prim_mode,
    input  logic [30:0]           vertex_count,
    input  logic [30:0]           first_vertex,
    input  logic [31:0]           element_index,
    input  logic                  drawn_now,
    output cmd_entry_t            entry
);

    logic             counting_en_reg;
    logic             restart_en_reg;
    logic [31:0]      restart_idx_reg;
    logic             in_block_reg, in_block_next;
    logic [CNT_W-1:0] pending_reg, pending_next;
    logic [3:0]       block_mode_reg, block_mode_next;

    logic [CNT_W-1:0] count_ext, first_ext, end_idx, n_head, n_tail;
    logic             split, elem_restart;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    assign count_ext    = CNT_W'(vertex_count);
    assign first_ext    = CNT_W'(first_vertex);
    assign end_idx      = first_ext + count_ext;
    assign split        = restart_en_reg && !restart_idx_reg[31] &&
                          (restart_idx_reg >= first_ext) && (restart_idx_reg < end_idx);
    assign n_head       = restart_idx_reg - first_ext;
    assign n_tail       = end_idx - restart_idx_reg - CNT_W'(1);
    assign elem_restart = restart_en_reg && (restart_idx_reg == element_index);

    always_comb
    begin
        entry           = '{op: OP_NONE, drawn: drawn_now, mode: prim_mode, n1: '0, n2: '0};
        in_block_next   = in_block_reg;
        pending_next    = pending_reg;
        block_mode_next = block_mode_reg;
        unique case (cmd_t'(cmd)) inside
            CMD_DRAW, CMD_DRAW_ARRAYS:
            begin
                if (counting_en_reg)
                begin
                    if (cmd_t'(cmd) == CMD_DRAW_ARRAYS && split)
                    begin
                        if (in_block_reg)
                            pending_next = sat_add(pending_reg, count_ext - CNT_W'(1));
                        else
                        begin
                            entry.op = OP_COUNT;
                            entry.n1 = n_head;
                            entry.n2 = n_tail;
                        end
                    end
                    else if (in_block_reg)
                        pending_next = sat_add(pending_reg, count_ext);
                    else
                    begin
                        entry.op = OP_COUNT;
                        entry.n1 = count_ext;
                    end
                end
            end
            CMD_BEGIN:
            begin
                in_block_next   = 1'b1;
                pending_next    = '0;
                block_mode_next = prim_mode;
            end
            CMD_END:
            begin
                if (counting_en_reg)
                begin
                    in_block_next   = 1'b0;
                    entry.op        = OP_COUNT;
                    entry.mode      = block_mode_reg;
                    entry.n1        = pending_reg;
                    block_mode_next = MODE_VERTICES;
                    pending_next    = '0;
                end
            end
            CMD_ARRAY_ELEM:
            begin
                if (elem_restart)
                begin
                    if (in_block_reg)
                    begin
                        if (counting_en_reg)
                        begin
                            entry.op   = OP_COUNT;
                            entry.mode = block_mode_reg;
                            entry.n1   = pending_reg;
                        end
                        pending_next = '0;
                    end
                end
                else if (counting_en_reg)
                begin
                    if (in_block_reg)
                        pending_next = sat_add(pending_reg, CNT_W'(1));
                    else
                    begin
                        entry.op   = OP_COUNT;
                        entry.mode = MODE_VERTICES;
                        entry.n1   = CNT_W'(1);
                    end
                end
            end
            CMD_FRAME_END: entry.op = OP_FRAME;
            CMD_CLEAR:     entry.op = OP_CLEAR;
            default:       entry.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counting_en_reg <= 1'b0;
            restart_en_reg  <= 1'b0;
            restart_idx_reg <= '0;
            in_block_reg    <= 1'b0;
            pending_reg     <= '0;
            block_mode_reg  <= MODE_VERTICES;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    REG_COUNTING_EN: counting_en_reg <= cfg_data[0];
                    REG_RESTART_EN:  restart_en_reg  <= cfg_data[0];
                    REG_RESTART_IDX: restart_idx_reg <= cfg_data;
                    default:         ;
                endcase
            end
            if (accept)
            begin
                in_block_reg   <= in_block_next;
                pending_reg    <= pending_next;
                block_mode_reg <= block_mode_next;
            end
        end
    end

endmodule

>>> design/pstat_cmd_queue.sv
// Short word queue between the front end and the counting back end.
// Uses pstat_pkg for the word type and depth.
module pstat_cmd_queue
    import pstat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  cmd_entry_t wr_data,
    output logic       full,
    input  logic       rd_en,
    output cmd_entry_t rd_data,
    output logic       empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);

    cmd_entry_t        mem [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg;

    assign full    = (count_reg == CNT_QW'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + CNT_QW'(wr_en) - CNT_QW'(rd_en);
        end
    end

endmodule

>>> design/pstat_back.sv
// Back end: primitive counts per batch, frame and total counters, result queue.
// Three stages: divide-by-three multiply, primitive count, counter update.
// Uses pstat_pkg.
module pstat_back
    import pstat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_entry_t q_data,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output result_t    head
);

    localparam logic [CNT_W-1:0] DIV3_RECIP = 32'hAAAA_AAAB;  // floor(n/3) = n*R >> 33
    localparam int DIV3_SHIFT = 33;
    localparam int OPTR_W = $clog2(OUT_DEPTH);
    localparam int OCNT_W = $clog2(OUT_DEPTH + 1);

    // stage 1: word plus n/3 quotients
    logic             s1_valid_reg;
    cmd_entry_t       s1_reg;
    logic [CNT_W-1:0] s1_q1_reg, s1_q2_reg;
    // stage 2: summed primitive and vertex counts
    logic             s2_valid_reg;
    op_t              s2_op_reg;
    logic             s2_drawn_reg;
    logic [1:0]       s2_slot_reg;
    logic [CNT_W:0]   s2_psum_reg, s2_nsum_reg;
    logic [CNT_W-1:0] s2_added_reg;
    // counters
    logic [CTR_W-1:0]    frame_reg [NUM_SLOTS];
    logic [CTR_W-1:0]    frame_next [NUM_SLOTS];
    logic [CTR_W-1:0]    total_reg [NUM_SLOTS];
    logic [CTR_W-1:0]    total_next [NUM_SLOTS];
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    // result queue
    result_t           omem [OUT_DEPTH];
    logic [OPTR_W-1:0] owr_ptr_reg, ord_ptr_reg;
    logic [OCNT_W-1:0] ocount_reg;

    logic             adv, opush, opop, ofull;
    logic [CNT_W-1:0] div_in1, div_in2;
    logic [2*CNT_W-1:0] prod1, prod2;
    logic [CNT_W-1:0] p1, p2;
    logic [CNT_W:0]   psum, nsum;
    logic [1:0]       slot;
    logic [CNT_W-1:0] added;
    result_t          res;

    function automatic logic [1:0] prim_slot(input logic [3:0] m);
        logic [1:0] s;
        unique case (m) inside
            MODE_POINTS: s = SLOT_POINTS;
            MODE_LINES, MODE_LINE_LOOP, MODE_LINE_STRIP,
            MODE_LINES_ADJ, MODE_STRIP_ADJ: s = SLOT_LINES;
            MODE_TRIS, MODE_TRI_STRIP, MODE_FAN, MODE_QUADS, MODE_QUAD_STRIP,
            MODE_POLYGON, MODE_TRIS_ADJ, MODE_TSTRIP_ADJ: s = SLOT_TRIS;
            default: s = SLOT_VERTS;
        endcase
        return s;
    endfunction

    // q3 is n/3 for triangles and (n/2)/3 for triangles with adjacency
    function automatic logic [CNT_W-1:0] prims_of(input logic [CNT_W-1:0] n,
                                                  input logic [3:0] m,
                                                  input logic [CNT_W-1:0] q3);
        logic [CNT_W-1:0] p;
        unique case (m) inside
            MODE_POINTS:     p = n;
            MODE_LINES:      p = n >> 1;
            MODE_LINE_LOOP:  p = (n < CNT_W'(2)) ? '0 : ((n == CNT_W'(2)) ? CNT_W'(1) : n);
            MODE_LINE_STRIP: p = (n < CNT_W'(2)) ? '0 : n - CNT_W'(1);
            MODE_TRIS, MODE_TRIS_ADJ: p = q3;
            MODE_TRI_STRIP, MODE_FAN, MODE_POLYGON:
                p = (n < CNT_W'(3)) ? '0 : n - CNT_W'(2);
            MODE_QUADS:      p = (n >> 2) << 1;
            MODE_QUAD_STRIP: p = (n < CNT_W'(4)) ? '0 : ((n >> 1) - CNT_W'(1)) << 1;
            MODE_LINES_ADJ:  p = n >> 2;
            MODE_STRIP_ADJ:  p = (n < CNT_W'(4)) ? '0 : n - CNT_W'(3);
            MODE_TSTRIP_ADJ: p = (n < CNT_W'(6)) ? '0 : (n - CNT_W'(4)) >> 1;
            default:         p = '0;
        endcase
        return p;
    endfunction

    function automatic logic [CTR_W-1:0] sat_ctr(input logic [CTR_W-1:0] a,
                                                 input logic [CTR_W:0] b);
        logic [CTR_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s[CTR_W+1:CTR_W] != 2'b00) ? '1 : s[CTR_W-1:0];
    endfunction

    // whole pipeline moves when the result queue can take a word
    assign ofull = (ocount_reg == OCNT_W'(OUT_DEPTH));
    assign empty = (ocount_reg == '0);
    assign opop  = pop && !empty;
    assign adv   = !ofull || opop;
    assign q_pop = adv && q_valid;
    assign opush = adv && s2_valid_reg;
    assign head  = omem[ord_ptr_reg];

    // stage 1 math
    assign div_in1 = (q_data.mode == MODE_TRIS_ADJ) ? (q_data.n1 >> 1) : q_data.n1;
    assign div_in2 = (q_data.mode == MODE_TRIS_ADJ) ? (q_data.n2 >> 1) : q_data.n2;
    assign prod1   = div_in1 * DIV3_RECIP;
    assign prod2   = div_in2 * DIV3_RECIP;

    // stage 2 math
    assign p1    = prims_of(s1_reg.n1, s1_reg.mode, s1_q1_reg);
    assign p2    = prims_of(s1_reg.n2, s1_reg.mode, s1_q2_reg);
    assign slot  = prim_slot(s1_reg.mode);
    assign psum  = {1'b0, p1} + {1'b0, p2};
    assign nsum  = {1'b0, s1_reg.n1} + {1'b0, s1_reg.n2};
    assign added = (s1_reg.op != OP_COUNT || !s1_reg.drawn || slot == SLOT_VERTS) ? '0 :
                   (psum[CNT_W] ? '1 : psum[CNT_W-1:0]);

    // stage 3: counter update
    always_comb
    begin
        frames_next = frames_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            frame_next[i] = frame_reg[i];
            total_next[i] = total_reg[i];
        end
        if (s2_valid_reg)
        begin
            unique case (s2_op_reg)
                OP_COUNT:
                begin
                    if (s2_drawn_reg)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (2'(i) == SLOT_VERTS)
                                frame_next[i] = sat_ctr(frame_reg[i], (CTR_W+1)'(s2_nsum_reg));
                            else if (2'(i) == s2_slot_reg)
                                frame_next[i] = sat_ctr(frame_reg[i], (CTR_W+1)'(s2_psum_reg));
                        end
                    end
                end
                OP_FRAME:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        total_next[i] = sat_ctr(total_reg[i], {1'b0, frame_reg[i]});
                        frame_next[i] = '0;
                    end
                    frames_next = (frames_reg == '1) ? frames_reg : frames_reg + FRAMES_W'(1);
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                        total_next[i] = '0;
                    frames_next = '0;
                end
                default: ;
            endcase
        end
        res.points = total_next[SLOT_POINTS];
        res.lines  = total_next[SLOT_LINES];
        res.tris   = total_next[SLOT_TRIS];
        res.verts  = total_next[SLOT_VERTS];
        res.frames = frames_next;
        res.added  = s2_added_reg;
    end

    // data path registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg       <= q_data;
            s1_q1_reg    <= CNT_W'(prod1[2*CNT_W-1:DIV3_SHIFT]);
            s1_q2_reg    <= CNT_W'(prod2[2*CNT_W-1:DIV3_SHIFT]);
            s2_op_reg    <= s1_reg.op;
            s2_drawn_reg <= s1_reg.drawn;
            s2_slot_reg  <= slot;
            s2_psum_reg  <= psum;
            s2_nsum_reg  <= nsum;
            s2_added_reg <= added;
        end
        if (opush)
            omem[owr_ptr_reg] <= res;
    end

    // control and counter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            owr_ptr_reg  <= '0;
            ord_ptr_reg  <= '0;
            ocount_reg   <= '0;
            frames_reg   <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                frame_reg[i] <= '0;
                total_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= q_valid;
                s2_valid_reg <= s1_valid_reg;
                frames_reg   <= frames_next;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    frame_reg[i] <= frame_next[i];
                    total_reg[i] <= total_next[i];
                end
            end
            if (opush)
                owr_ptr_reg <= owr_ptr_reg + OPTR_W'(1);
            if (opop)
                ord_ptr_reg <= ord_ptr_reg + OPTR_W'(1);
            ocount_reg <= ocount_reg + OCNT_W'(opush) - OCNT_W'(opop);
        end
    end

    a_pop_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("command queue popped while empty");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        ocount_reg <= OCNT_W'(OUT_DEPTH))
        else $error("result queue overflow");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (opush && s2_op_reg == OP_CLEAR) |=>
            (frames_reg == '0 && total_reg[SLOT_POINTS] == '0 &&
             total_reg[SLOT_VERTS] == '0))
        else $error("clear left totals nonzero");

    a_frame_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (opush && s2_op_reg == OP_FRAME) |=>
            (frame_reg[SLOT_POINTS] == '0 && frame_reg[SLOT_LINES] == '0 &&
             frame_reg[SLOT_TRIS] == '0 && frame_reg[SLOT_VERTS] == '0))
        else $error("frame end left frame counters nonzero");

endmodule

>>> design/primitive_statistics_counter_top.sv
// Primitive statistics counter, top level.
// Path: a pushed command goes through the queue write, the divide-by-three multiply stage,
// the count stage and the counter update, which writes its result word.
// Throughput: one command per cycle while the result queue has room or is being popped.
// Reset (rst_n low, asynchronous) clears config, block state, counters, queues.
module primitive_statistics_counter_top
    import pstat_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // command side
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            cmd,
    input  logic [3:0]            prim_mode,
    input  logic [30:0]           vertex_count,
    input  logic [30:0]           first_vertex,
    input  logic [31:0]           element_index,
    input  logic                  drawn_now,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [CTR_W-1:0]      points_total,
    output logic [CTR_W-1:0]      lines_total,
    output logic [CTR_W-1:0]      triangles_total,
    output logic [CTR_W-1:0]      vertices_total,
    output logic [FRAMES_W-1:0]   frame_count,
    output logic [CNT_W-1:0]      added_primitives
);

    logic       accept;
    cmd_entry_t front_word;
    cmd_entry_t q_head;
    logic       q_empty;
    logic       q_pop;
    result_t    head;

    // a pushed word goes in whenever the command queue has room
    assign accept = push && !full;

    // Front: decodes commands, tracks begin/end blocks and the restart split,
    // and holds the configuration registers.
    pstat_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .accept        (accept),
        .cmd           (cmd),
        .prim_mode     (prim_mode),
        .vertex_count  (vertex_count),
        .first_vertex  (first_vertex),
        .element_index (element_index),
        .drawn_now     (drawn_now),
        .entry         (front_word)
    );

    // Decouples the front from back-end stalls caused by a slow consumer.
    pstat_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_word),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    // Back: primitive counts, frame/total counters and the result queue.
    pstat_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (!q_empty),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .head    (head)
    );

    assign points_total     = head.points;
    assign lines_total      = head.lines;
    assign triangles_total  = head.tris;
    assign vertices_total   = head.verts;
    assign frame_count      = head.frames;
    assign added_primitives = head.added;

endmodule
